### rtl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg: shared types and constants for the decimal scale reducer
// Request and result payload structs, and the chunk divide-by-ten constants.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int unsigned MantW   = 192;
  localparam int unsigned ResW    = 96;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned ExpOutW = 5;
  localparam int unsigned ChunkW  = 16;
  localparam int unsigned NumChunks = MantW / ChunkW;
  localparam int unsigned CntW    = $clog2(NumChunks);
  localparam int unsigned DigitW  = 4;
  localparam int unsigned DivInW  = ChunkW + DigitW;
  localparam int unsigned RecipW  = 20;
  localparam int unsigned RecipSh = 23;
  localparam logic [RecipW-1:0] Recip10 = 20'd838861;
  localparam logic [ExpW-1:0]   MaxExp  = 8'd28;
  localparam logic [DigitW-1:0] HalfDigit = 4'd5;

  typedef struct packed {
    logic [63:0]     mant_w0;
    logic [63:0]     mant_w1;
    logic [63:0]     mant_w2;
    logic [ExpW-1:0] exponent_in;
    logic            sign_in;
  } in_req_t;

  typedef struct packed {
    logic [63:0]        res_low;
    logic [31:0]        res_high;
    logic [ExpOutW-1:0] exponent_out;
    logic               sign_out;
    logic               too_large;
  } out_res_t;

endpackage

### rtl/decimal_scale_reduce_round_even.sv
// Each divide-by-ten step passes every 16-bit chunk through the shared divider,
// then rounds and checks again; up to 255 steps. No new request is taken until
// the last one is finished (in_stall_o is high outside idle).
// A new request is taken while a finished result waits at the output.
// Reset (rst_ni low, asynchronous) returns to idle with no pending result.
// ----------------------------------------------------------------------------
// decimal_scale_reduce_round_even: fit a 192-bit decimal mantissa into 96 bits
// Repeated divide by ten with round half to even until the value fits and the
// exponent is at most 28; flags overflow when the exponent is zero but the value still does not fit.
// ----------------------------------------------------------------------------
module decimal_scale_reduce_round_even import dsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDiv,
    StRound,
    StDone
  } state_e;

  state_e            state_q;
  logic [MantW-1:0]  mant_q;
  logic [ExpW-1:0]   exp_q;
  logic              sign_q;
  logic              ovf_q;
  logic [DigitW-1:0] rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  out_res_t          out_q;

  logic [ChunkW-1:0] quot;
  logic [DigitW-1:0] rem_next;
  logic              upper_nz;
  logic              round_up;
  logic              out_free;

  dsr_div10_chunk u_div10 (
    .rem_i   (rem_q),
    .chunk_i (mant_q[MantW-1 -: ChunkW]),
    .quot_o  (quot),
    .rem_o   (rem_next)
  );

  assign upper_nz = |mant_q[MantW-1:ResW];
  assign round_up = (rem_q > HalfDigit) || ((rem_q == HalfDigit) && mant_q[0]);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mant_q      <= '0;
      exp_q       <= '0;
      sign_q      <= 1'b0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            mant_q  <= {in_data_i.mant_w2, in_data_i.mant_w1, in_data_i.mant_w0};
            exp_q   <= in_data_i.exponent_in;
            sign_q  <= in_data_i.sign_in;
            ovf_q   <= 1'b0;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (upper_nz || (exp_q > MaxExp)) begin
            if (exp_q == '0) begin
              ovf_q   <= 1'b1;
              state_q <= StDone;
            end else begin
              rem_q   <= '0;
              cnt_q   <= CntW'(NumChunks - 1);
              state_q <= StDiv;
            end
          end else begin
            state_q <= StDone;
          end
        end
        StDiv: begin
          mant_q <= {mant_q[MantW-ChunkW-1:0], quot};
          rem_q  <= rem_next;
          if (cnt_q == '0) begin
            state_q <= StRound;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        StRound: begin
          mant_q  <= mant_q + MantW'(round_up);
          exp_q   <= exp_q - 1'b1;
          state_q <= StCheck;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.sign_out     <= sign_q;
            out_q.too_large    <= ovf_q;
            if (ovf_q) begin
              out_q.res_low      <= '0;
              out_q.res_high     <= '0;
              out_q.exponent_out <= '0;
            end else begin
              out_q.res_low      <= mant_q[63:0];
              out_q.res_high     <= mant_q[95:64];
              out_q.exponent_out <= exp_q[ExpOutW-1:0];
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/dsr_div10_chunk.sv
// ----------------------------------------------------------------------------
// dsr_div10_chunk: divide one 16-bit chunk plus carried remainder by ten
// Reciprocal multiply gives the quotient; the remainder is recovered by a
// multiply-by-ten subtract.
// ----------------------------------------------------------------------------
module dsr_div10_chunk import dsr_pkg::*; (
  input  logic [DigitW-1:0] rem_i,
  input  logic [ChunkW-1:0] chunk_i,
  output logic [ChunkW-1:0] quot_o,
  output logic [DigitW-1:0] rem_o
);

  logic [DivInW-1:0]        num;
  logic [DivInW+RecipW-1:0] prod;
  logic [ChunkW-1:0]        quot;
  logic [DivInW-1:0]        quot_x10;
  logic [DivInW-1:0]        diff;

  assign num      = {rem_i, chunk_i};
  assign prod     = (DivInW + RecipW)'(num) * (DivInW + RecipW)'(Recip10);
  assign quot     = prod[RecipSh +: ChunkW];
  assign quot_x10 = (DivInW'(quot) << 3) + (DivInW'(quot) << 1);
  assign diff     = num - quot_x10;
  assign quot_o   = quot;
  assign rem_o    = diff[DigitW-1:0];

endmodule
